// ===== src/encnav_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and small arithmetic helpers for the encoder and
// long-press navigator. No dependencies.
package encnav_pkg;

	localparam int unsigned MAX_SCREENS = 16;
	localparam int unsigned SCREEN_LIMIT = (MAX_SCREENS < 16) ? MAX_SCREENS : 16;
	localparam logic [4:0] SCREEN_LIMIT_W = 5'(SCREEN_LIMIT);
	localparam logic [16:0] PRESS_MAX = 17'h1FFFF;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_COUNT = 3'd0,
		REG_EDGE_QUIET   = 3'd1,
		REG_POLL_PERIOD  = 3'd2,
		REG_SHORT_MIN    = 3'd3,
		REG_LONG_PRESS   = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		ACT_EDGE = 1'b0,
		ACT_POLL = 1'b1
	} action_t;

	typedef struct packed {
		logic [4:0]  num_screens;
		logic [9:0]  edge_quiet_ms;
		logic [9:0]  poll_period_ms;
		logic [15:0] short_min_ms;
		logic [15:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic        action;
		logic        data_level;
		logic [31:0] time_ms;
		logic        button_level;
	} item_t;

	typedef struct packed {
		logic [3:0] screen;
		logic       edge_accepted;
		logic       short_click;
		logic       alarm_fire;
	} result_t;

	// Clamp the programmed count into 1..SCREEN_LIMIT.
	function automatic logic [4:0] eff_count(logic [4:0] sc);
		logic [4:0] n;
		n = sc;
		if (n == 5'd0)
			n = 5'd1;
		if (n > SCREEN_LIMIT_W)
			n = SCREEN_LIMIT_W;
		return n;
	endfunction

	// Four-step restoring remainder of a 4-bit value by n (1..16).
	function automatic logic [3:0] mod_n(logic [3:0] x, logic [4:0] n);
		logic [4:0] r;
		r = '0;
		for (int i = 3; i >= 0; i--) begin
			r = {r[3:0], x[i]};
			if (r >= n)
				r = r - n;
		end
		return r[3:0];
	endfunction

	// a + b modulo n, with a and b already below n.
	function automatic logic [3:0] add_wrap(logic [3:0] a, logic [3:0] b, logic [4:0] n);
		logic [4:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= n)
			s = s - n;
		return s[3:0];
	endfunction

endpackage

// ===== src/encnav_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file for the navigator.
// Depends on encnav_pkg.
module encnav_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [encnav_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [encnav_pkg::CFG_DATA_W-1:0]   cfg_data,
	output encnav_pkg::cfg_t                    cfg
);
	import encnav_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_screens    <= 5'd4;
			cfg_q.edge_quiet_ms  <= 10'd50;
			cfg_q.poll_period_ms <= 10'd100;
			cfg_q.short_min_ms   <= 16'd50;
			cfg_q.long_press_ms  <= 16'd3000;
		end else if (cfg_we) begin
			// unknown indexes drop the write
			unique case (cfg_index)
				REG_SCREEN_COUNT: cfg_q.num_screens    <= cfg_data[4:0];
				REG_EDGE_QUIET:   cfg_q.edge_quiet_ms  <= cfg_data[9:0];
				REG_POLL_PERIOD:  cfg_q.poll_period_ms <= cfg_data[9:0];
				REG_SHORT_MIN:    cfg_q.short_min_ms   <= cfg_data;
				REG_LONG_PRESS:   cfg_q.long_press_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/encnav_step.sv =====
`timescale 1ns / 1ps
// Navigator state and the single-pass update for one edge or poll item.
// Depends on encnav_pkg.
module encnav_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  encnav_pkg::item_t    item,
	input  encnav_pkg::cfg_t     cfg,
	output encnav_pkg::result_t  res
);
	import encnav_pkg::*;

	logic [31:0] last_edge_q;
	logic [3:0]  pending_q;
	logic [3:0]  screen_q;
	logic [16:0] press_q;
	logic        alarm_q;

	logic [31:0] last_edge_d;
	logic [3:0]  pending_d;
	logic [3:0]  screen_d;
	logic [16:0] press_d;
	logic        alarm_d;

	logic [4:0]  n;
	logic [3:0]  p_red;
	logic [3:0]  s_red;
	logic [3:0]  s_moved;
	logic [31:0] elapsed;
	logic [17:0] press_sum;
	logic [16:0] press_sat;
	logic        accepted;
	logic        click;
	logic        fire;

	always_comb begin
		n         = eff_count(cfg.num_screens);
		p_red     = mod_n(pending_q, n);
		s_red     = mod_n(screen_q, n);
		elapsed   = item.time_ms - last_edge_q;
		press_sum = {1'b0, press_q} + {8'd0, cfg.poll_period_ms};
		press_sat = (press_sum > {1'b0, PRESS_MAX}) ? PRESS_MAX : press_sum[16:0];

		last_edge_d = last_edge_q;
		pending_d   = pending_q;
		screen_d    = screen_q;
		press_d     = press_q;
		alarm_d     = alarm_q;
		accepted    = 1'b0;
		click       = 1'b0;
		fire        = 1'b0;
		s_moved     = s_red;

		unique case (action_t'(item.action))
			ACT_EDGE: begin
				if (elapsed > {22'd0, cfg.edge_quiet_ms}) begin
					accepted    = 1'b1;
					last_edge_d = item.time_ms;
					if (item.data_level)
						pending_d = add_wrap(p_red, 4'd1, n);
					else
						pending_d = (p_red == 4'd0) ? 4'(n - 5'd1) : p_red - 4'd1;
				end
			end
			ACT_POLL: begin
				pending_d = '0;
				if (p_red != 4'd0) begin
					s_moved  = add_wrap(s_red, p_red, n);
					screen_d = s_moved;
				end
				if (!item.button_level) begin
					press_d = press_sat;
					if ((press_sat >= {1'b0, cfg.long_press_ms}) && !alarm_q) begin
						alarm_d = 1'b1;
						fire    = 1'b1;
					end
				end else begin
					if ((press_q >= {1'b0, cfg.short_min_ms}) &&
					    (press_q < {1'b0, cfg.long_press_ms})) begin
						screen_d = add_wrap(s_moved, 4'd1, n);
						click    = 1'b1;
					end
					press_d = '0;
					alarm_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			pending_q   <= '0;
			screen_q    <= '0;
			press_q     <= '0;
			alarm_q     <= 1'b0;
		end else if (en) begin
			last_edge_q <= last_edge_d;
			pending_q   <= pending_d;
			screen_q    <= screen_d;
			press_q     <= press_d;
			alarm_q     <= alarm_d;
		end
	end

	assign res.screen        = screen_d;
	assign res.edge_accepted = accepted;
	assign res.short_click   = click;
	assign res.alarm_fire    = fire;

endmodule

// ===== src/encoder_and_long_press_navigator_top.sv =====
`timescale 1ns / 1ps
// Top level of the encoder and long-press navigator: input register, state
// update and result register. Depends on encnav_pkg, encnav_cfg, encnav_step.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one item per transfer: an encoder
//   falling edge (action 0, data_level, time_ms) or a poll tick (action 1,
//   button_level). Unused fields of an item are ignored.
// - Output channel (out_valid/out_ready) returns exactly one result per item:
//   screen index after the item plus edge_accepted, short_click, alarm_fire.
// - The input register takes the item at the transfer; the result register
//   loads from the state update once it is free, and out_valid rises with it.
//   Throughput: one item per cycle while the receiver keeps taking results,
//   set by the single registered pass from the input register through the
//   state update into the result register.
// - When the receiver stalls, the result register holds and the input register
//   takes one more item; in_ready then drops until the result is taken.
// - Configuration (cfg_we, cfg_index, cfg_data) writes a register in one cycle
//   and should be done while no item is in flight.
// - Reset clears all state, screen index 0, and loads the default registers;
//   no clearing pass is needed, items are taken right after reset.
module encoder_and_long_press_navigator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic                                data_level,
	input  logic [31:0]                         time_ms,
	input  logic                                button_level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [3:0]                          screen,
	output logic                                edge_accepted,
	output logic                                short_click,
	output logic                                alarm_fire,
	input  logic                                cfg_we,
	input  logic [encnav_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [encnav_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import encnav_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;

	// advance the stage-1 item when the result register is free
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action       <= action;
			item_s1.data_level   <= data_level;
			item_s1.time_ms      <= time_ms;
			item_s1.button_level <= button_level;
		end
		if (adv)
			res_s2 <= res;
	end

	encnav_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	encnav_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid     = valid_s2;
	assign screen        = res_s2.screen;
	assign edge_accepted = res_s2.edge_accepted;
	assign short_click   = res_s2.short_click;
	assign alarm_fire    = res_s2.alarm_fire;

endmodule

// ===== src/encnav_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the navigator top, attached by bind.
// Depends only on the top level's ports.
module encnav_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] screen,
	input logic       edge_accepted,
	input logic       short_click,
	input logic       alarm_fire
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(screen) &&
		$stable(edge_accepted) && $stable(short_click) && $stable(alarm_fire))
		else $error("stalled result changed");

	// an edge result never carries button events
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_accepted |-> !short_click && !alarm_fire)
		else $error("edge result flagged a button event");

	// every transfer is followed by a valid result on the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("result missing two cycles after transfer");

	// input only backs up behind a full result register
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result register");

endmodule

bind encoder_and_long_press_navigator_top encnav_chk u_encnav_chk (.*);

// ===== tb/tb_encoder_and_long_press_navigator_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for encoder_and_long_press_navigator_top: directed and random
// encoder edges and poll ticks over several register settings, checked against a
// cycle-free navigation model. Depends on encnav_pkg and the top level.
module tb_encoder_and_long_press_navigator_top;
	import encnav_pkg::*;

	localparam int CLK_HALF_NS = 5;
	localparam int RESET_CYCLES = 9;
	localparam int PHASE_ITEMS = 150;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int MAX_PRESS_POLLS = 160;
	localparam int MAX_REPORTS = 100;
	localparam longint LIMIT_NS = 5_000_000;

	// Indexes past the register list; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 3'd7;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN,
		RX_HEAVY
	} stall_mode_t;

	class nav_scoreboard;
		logic [4:0] num_screens;
		logic [9:0] edge_quiet;
		logic [9:0] poll_period;
		logic [15:0] short_min;
		logic [15:0] long_press;

		logic [31:0] last_edge;
		logic [3:0] pending;
		logic [3:0] screen_idx;
		logic [16:0] press;
		bit latched;

		result_t screens_due[$];
		int n_items, n_results, n_errors;
		int n_accepted, n_clicks, n_alarms;

		function new();
			num_screens = 5'd4;
			edge_quiet = 10'd50;
			poll_period = 10'd100;
			short_min = 16'd50;
			long_press = 16'd3000;
			last_edge = '0;
			pending = '0;
			screen_idx = '0;
			press = '0;
			latched = 1'b0;
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SCREEN_COUNT: num_screens = data[4:0];
				REG_EDGE_QUIET: edge_quiet = data[9:0];
				REG_POLL_PERIOD: poll_period = data[9:0];
				REG_SHORT_MIN: short_min = data[15:0];
				REG_LONG_PRESS: long_press = data[15:0];
				default: ;
			endcase
		endfunction

		// Advance the navigation state by one transfer and queue the result it gives.
		function void advance_navigation(action_t act, logic dt, logic [31:0] t_ms,
				logic btn);
			int unsigned n, p, t;
			logic [31:0] gap;
			result_t r;
			n = num_screens;
			if (n == 0)
				n = 1;
			if (n > MAX_SCREENS)
				n = MAX_SCREENS;
			if (n > 16)
				n = 16;
			r = '0;
			if (act == ACT_EDGE) begin
				gap = t_ms - last_edge;
				if (gap > {22'b0, edge_quiet}) begin
					p = pending % n;
					if (dt)
						p = (p + 1) % n;
					else
						p = (p + n - 1) % n;
					pending = 4'(p);
					last_edge = t_ms;
					r.edge_accepted = 1'b1;
				end
			end else begin
				p = pending % n;
				if (p != 0)
					screen_idx = 4'((screen_idx % n + p) % n);
				pending = '0;
				if (btn == 1'b0) begin
					t = press + poll_period;
					press = (t > PRESS_MAX) ? PRESS_MAX : 17'(t);
					if (press >= long_press && !latched) begin
						latched = 1'b1;
						r.alarm_fire = 1'b1;
					end
				end else begin
					if (press >= short_min && press < long_press) begin
						screen_idx = 4'((screen_idx % n + 1) % n);
						r.short_click = 1'b1;
					end
					press = '0;
					latched = 1'b0;
				end
			end
			r.screen = screen_idx;
			n_items++;
			n_accepted += r.edge_accepted;
			n_clicks += r.short_click;
			n_alarms += r.alarm_fire;
			screens_due.push_back(r);
		endfunction

		function void check_result(logic [3:0] scr, logic acc, logic click, logic fire);
			result_t want;
			if (screens_due.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: result with nothing outstanding: ", $time,
						"screen %0d acc %0b click %0b fire %0b",
						scr, acc, click, fire);
				return;
			end
			want = screens_due.pop_front();
			n_results++;
			if (scr !== want.screen || acc !== want.edge_accepted ||
					click !== want.short_click || fire !== want.alarm_fire) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: mismatch: expected screen %0d acc %0b ", $time,
						want.screen, want.edge_accepted,
						"click %0b fire %0b, ", want.short_click, want.alarm_fire,
						"got screen %0d acc %0b click %0b fire %0b",
						scr, acc, click, fire);
			end
		endfunction

		function int outstanding();
			return screens_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic action;
	logic data_level;
	logic [31:0] time_ms;
	logic button_level;
	logic out_valid;
	logic out_ready;
	logic [3:0] screen;
	logic edge_accepted;
	logic short_click;
	logic alarm_fire;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	nav_scoreboard sb;
	stall_mode_t rx_mode = RX_RANDOM;
	bit long_hold_req = 1'b0;
	bit steady_tx = 1'b0;
	int burst_left = 0;
	int n_settings = 0;
	logic [31:0] now_ms = '0;

	encoder_and_long_press_navigator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.data_level(data_level),
		.time_ms(time_ms),
		.button_level(button_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.screen(screen),
		.edge_accepted(edge_accepted),
		.short_click(short_click),
		.alarm_fire(alarm_fire),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#(CLK_HALF_NS) clk = 1'b1;
		#(CLK_HALF_NS) clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(screen, edge_accepted, short_click, alarm_fire);
	end

	// Receiver: stall pattern per phase, plus a long hold-off on request.
	initial begin
		int tick;
		tick = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end else begin
				tick++;
				case (rx_mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
					RX_PATTERN: out_ready <= ((tick % 7) < 4);
					default: out_ready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Timeout with %0d results outstanding", sb.outstanding());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_item(action_t act, logic dt, logic [31:0] t, logic btn);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady_tx ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
				action <= 1'($urandom_range(0, 1));
				time_ms <= $urandom;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		data_level <= dt;
		time_ms <= t;
		button_level <= btn;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.advance_navigation(act, dt, t, btn);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic settle_block();
		pause_until_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.apply_reg(idx, data);
	endtask

	task automatic set_config(logic [15:0] sc, logic [15:0] q, logic [15:0] per,
			logic [15:0] sm, logic [15:0] lp, bit spare);
		write_reg(REG_SCREEN_COUNT, sc);
		write_reg(REG_EDGE_QUIET, q);
		write_reg(REG_POLL_PERIOD, per);
		write_reg(REG_SHORT_MIN, sm);
		write_reg(REG_LONG_PRESS, lp);
		if (spare) begin
			write_reg(REG_SPARE_0, 16'($urandom));
			write_reg(REG_SPARE_1, 16'($urandom));
			write_reg(REG_SPARE_2, 16'hFFFF);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Step the edge clock around the quiet window, with jumps and wraps.
	task automatic send_edge(bit prefer_count);
		logic [31:0] q;
		int unsigned pick;
		q = {22'b0, sb.edge_quiet};
		pick = prefer_count ? 3 : $urandom_range(0, 9);
		case (pick)
			0: now_ms += q;
			1: now_ms += q + 1;
			2: now_ms += $urandom_range(0, q);
			7: now_ms = $urandom;
			8: now_ms = 32'hFFFF_FFFF - $urandom_range(0, q);
			9: now_ms += $urandom_range(0, 2 * q + 2);
			default: now_ms += q + 1 + $urandom_range(0, 200);
		endcase
		send_item(ACT_EDGE, 1'($urandom_range(0, 1)), now_ms, 1'($urandom_range(0, 1)));
	endtask

	// Pick a hold length that lands near the click band edges, the alarm or the press saturation.
	function automatic int press_polls();
		int per, ks, kl, k;
		per = (sb.poll_period == 0) ? 1 : int'(sb.poll_period);
		ks = (int'(sb.short_min) + per - 1) / per;
		kl = (int'(sb.long_press) + per - 1) / per;
		case ($urandom_range(0, 7))
			0: k = 0;
			1: k = 1;
			2: k = ks;
			3: k = ks - 1;
			4: k = kl - 1;
			5: k = kl;
			6: k = kl + $urandom_range(1, 3);
			default: k = int'(PRESS_MAX) / per + 2;
		endcase
		if (k < 0)
			k = 0;
		if (k > MAX_PRESS_POLLS)
			k = $urandom_range(0, 6);
		return k;
	endfunction

	task automatic send_press();
		int k;
		k = press_polls();
		repeat (k) begin
			if ($urandom_range(0, 6) == 0)
				send_edge(1'b0);
			send_item(ACT_POLL, 1'($urandom_range(0, 1)), $urandom, 1'b0);
		end
		send_item(ACT_POLL, 1'($urandom_range(0, 1)), $urandom, 1'b1);
	endtask

	task automatic run_phase(logic [15:0] sc, logic [15:0] q, logic [15:0] per,
			logic [15:0] sm, logic [15:0] lp, bit spare, stall_mode_t mode, bit calm,
			bit hold_mid);
		int start, seg;
		bit mid_done;
		settle_block();
		set_config(sc, q, per, sm, lp, spare);
		rx_mode = mode;
		steady_tx = calm;
		start = sb.n_items;
		mid_done = 1'b0;
		while (sb.n_items - start < PHASE_ITEMS) begin
			if (!mid_done && sb.n_items - start >= PHASE_ITEMS / 2) begin
				mid_done = 1'b1;
				if (hold_mid)
					long_hold_req = 1'b1;
				else
					pause_until_drained();
			end
			seg = $urandom_range(0, 9);
			if (seg < 4)
				repeat ($urandom_range(1, 6)) send_edge(1'b0);
			else if (seg < 9)
				send_press();
			else
				send_item(action_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom, 1'($urandom_range(0, 1)));
		end
		// Leave steps pending so the next count works on a stale value.
		repeat (2) send_edge(1'b1);
	endtask

	initial begin
		int unsigned per, sm, lp;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		data_level = 1'b0;
		time_ms = '0;
		button_level = 1'b1;
		cfg_we = 1'b0;
		cfg_index = REG_SCREEN_COUNT;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Defaults: quiet boundary, wrap of the timestamp, net-zero steps, click.
		send_item(ACT_EDGE, 1'b1, 32'd0, 1'b1);
		send_item(ACT_EDGE, 1'b1, 32'd50, 1'b1);
		send_item(ACT_EDGE, 1'b1, 32'd51, 1'b0);
		send_item(ACT_EDGE, 1'b0, 32'd101, 1'b1);
		send_item(ACT_EDGE, 1'b0, 32'd102, 1'b0);
		send_item(ACT_POLL, 1'b1, 32'hFFFF_FFFF, 1'b1);
		send_item(ACT_EDGE, 1'b0, 32'd200, 1'b1);
		send_item(ACT_POLL, 1'b0, 32'd0, 1'b1);
		send_item(ACT_EDGE, 1'b1, 32'hFFFF_FFF0, 1'b0);
		send_item(ACT_EDGE, 1'b1, 32'h0000_0010, 1'b1);
		send_item(ACT_EDGE, 1'b1, 32'h0000_0040, 1'b1);
		send_item(ACT_POLL, 1'b1, 32'h5555_AAAA, 1'b0);
		send_item(ACT_POLL, 1'b0, 32'hAAAA_5555, 1'b1);
		now_ms = 32'h0000_0040;

		// Narrow band: below short, inside short band, long press with one alarm.
		settle_block();
		set_config(16'd4, 16'd50, 16'd100, 16'd150, 16'd250, 1'b0);
		send_item(ACT_POLL, 1'b0, 32'd0, 1'b0);
		send_item(ACT_POLL, 1'b0, 32'd0, 1'b1);
		repeat (2) send_item(ACT_POLL, 1'b1, 32'd7, 1'b0);
		send_item(ACT_POLL, 1'b0, 32'd0, 1'b1);
		repeat (4) send_item(ACT_POLL, 1'b0, 32'd9, 1'b0);
		send_item(ACT_POLL, 1'b0, 32'd0, 1'b1);

		run_phase(16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 1'b0, RX_ALWAYS, 1'b1, 1'b0);
		run_phase(16'd16, 16'd1000, 16'd1000, 16'd65535, 16'd65535, 1'b0, RX_RANDOM,
			1'b0, 1'b1);
		// Zero count, zero period and zero long-press threshold together.
		run_phase(16'd0, 16'd1023, 16'd0, 16'd0, 16'd0, 1'b0, RX_PATTERN, 1'b0, 1'b0);
		// Upper data bits set: count clamps, quiet time masks to its width.
		run_phase(16'hFFFF, 16'hFC05, 16'd37, 16'd100, 16'd500, 1'b1, RX_HEAVY, 1'b0,
			1'b1);
		run_phase(16'd3, 16'd20, 16'd250, 16'd250, 16'd1000, 1'b0, RX_RANDOM, 1'b1,
			1'b0);
		for (int i = 0; i < 4; i++) begin
			per = $urandom_range(1, 1000);
			sm = $urandom_range(0, per * 6);
			lp = sm + $urandom_range(1, per * 10);
			if (lp > 65535)
				lp = 65535;
			run_phase(16'($urandom_range(0, 31)), 16'($urandom_range(0, 1000)), 16'(per),
				16'(sm), 16'(lp), 1'b0, stall_mode_t'(i % 4), i == 2, i % 2 == 0);
		end

		pause_until_drained();
		rx_mode = RX_ALWAYS;
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d items over %0d register settings, ", sb.n_items,
			n_settings, "count limits and zero thresholds included.");
		$display("Edges accepted %0d, short clicks %0d, long-press alarms %0d, errors %0d.",
			sb.n_accepted, sb.n_clicks, sb.n_alarms, sb.n_errors);
		if (sb.n_errors == 0 && sb.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== encoder_and_long_press_navigator_top.f =====
src/encnav_pkg.sv
src/encnav_cfg.sv
src/encnav_step.sv
src/encoder_and_long_press_navigator_top.sv
src/encnav_chk.sv
tb/tb_encoder_and_long_press_navigator_top.sv
